[design/dxt3_pkg.sv]
// Shared types, register indexes and color arithmetic for the DXT3 block decoder.
package dxt3_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCKS_ACROSS = 2'd0,
		REG_BLOCKS_DOWN   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	// 5-bit to 8-bit: (v*527+23)>>6
	function automatic logic [7:0] widen5(input logic [4:0] v);
		logic [14:0] acc;
		acc = 15'(v) * 15'd527 + 15'd23;
		return acc[13:6];
	endfunction

	// 6-bit to 8-bit: (v*259+33)>>6
	function automatic logic [7:0] widen6(input logic [5:0] v);
		logic [14:0] acc;
		acc = 15'(v) * 15'd259 + 15'd33;
		return acc[13:6];
	endfunction

	function automatic rgb_t expand565(input logic [15:0] c);
		rgb_t p;
		p.blue  = widen5(c[4:0]);
		p.green = widen6(c[10:5]);
		p.red   = widen5(c[15:11]);
		return p;
	endfunction

	// floor((2*major+minor)/3) via reciprocal 683/2048, one lower on an exact
	// multiple of 3 when minor exceeds major. Low product bits stay below 683
	// exactly when the sum divides by 3.
	function automatic logic [7:0] third_mix(input logic [7:0] major, input logic [7:0] minor);
		logic [9:0]  s;
		logic [19:0] prod;
		logic [7:0]  q;
		logic        exact;
		s     = {1'b0, major, 1'b0} + 10'(minor);
		prod  = 20'(s) * 20'd683;
		q     = prod[18:11];
		exact = prod[10:0] < 11'd683;
		if (exact && (minor > major) && (q != 8'd0)) begin
			q = q - 8'd1;
		end
		return q;
	endfunction

endpackage

[design/dxt3_palette.sv]
// Interpolated colors 2 and 3 from the two widened end colors.
module dxt3_palette
	import dxt3_pkg::*;
(
	input  rgb_t e0,
	input  rgb_t e1,
	output rgb_t c2,
	output rgb_t c3
);

	always_comb begin
		c2.blue  = third_mix(e0.blue,  e1.blue);
		c2.green = third_mix(e0.green, e1.green);
		c2.red   = third_mix(e0.red,   e1.red);
		c3.blue  = third_mix(e1.blue,  e0.blue);
		c3.green = third_mix(e1.green, e0.green);
		c3.red   = third_mix(e1.red,   e0.red);
	end

endmodule

[design/dxt3_block_decoder_core.sv]
// Top level of the DXT3 block decoder: block intake, palette stage and pixel output.
// Each accepted 16-byte DXT3 block yields 16 pixels in row-major order, one pixel per
// cycle while out_ready does not stall the output register; the input register takes
// the next block while the current one is still being emitted, and blocks stream back
// to back when out_ready stays high. A block passes through the input register with
// widened end colors, then the palette register, then the output register. Blocks
// arrive in raster order;
// the block column and row counters wrap at blocks_across and blocks_down (0 is
// taken as 1, sizes above the maximum parameters are clamped). Configuration is
// written through cfg_valid/cfg_index/cfg_data, always ready, and must only be
// written while the block is idle.
module dxt3_block_decoder_core
	import dxt3_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS_ACROSS = 1024,
	parameter int unsigned MAX_BLOCKS_DOWN   = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [63:0]           alpha_word,
	input  logic [63:0]           color_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_green,
	output logic [7:0]            out_red,
	output logic [7:0]            out_alpha,
	output logic [11:0]           pixel_x,
	output logic [11:0]           pixel_y,
	output logic                  last_of_block,
	output logic                  last_of_image
);

	localparam int unsigned CW = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
	localparam int unsigned RW = (MAX_BLOCKS_DOWN > 1) ? $clog2(MAX_BLOCKS_DOWN) : 1;
	localparam logic [13:0] MAX_ACROSS_C = 14'(MAX_BLOCKS_ACROSS);
	localparam logic [13:0] MAX_DOWN_C   = 14'(MAX_BLOCKS_DOWN);

	// configuration
	logic [CFG_DATA_W-1:0] blocks_across_q, blocks_down_q;
	logic [13:0]           across_eff, down_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_across_q <= CFG_DATA_W'(64);
			blocks_down_q   <= CFG_DATA_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLOCKS_ACROSS: blocks_across_q <= cfg_data;
				REG_BLOCKS_DOWN:   blocks_down_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (blocks_across_q == '0)                 across_eff = 14'd1;
		else if (14'(blocks_across_q) > MAX_ACROSS_C)       across_eff = MAX_ACROSS_C;
		else                                                across_eff = 14'(blocks_across_q);
		priority if (blocks_down_q == '0)                   down_eff = 14'd1;
		else if (14'(blocks_down_q) > MAX_DOWN_C)           down_eff = MAX_DOWN_C;
		else                                                down_eff = 14'(blocks_down_q);
	end

	// handshake control
	logic       a_valid_s1, b_valid_s2, out_valid_s3;
	logic [3:0] pix_cnt_s2;
	logic       in_xfer, b_take, out_load, b_done;

	assign out_load = b_valid_s2 && (!out_valid_s3 || out_ready);
	assign b_done   = out_load && (pix_cnt_s2 == 4'd15);
	assign b_take   = a_valid_s1 && (!b_valid_s2 || b_done);
	assign in_ready = !a_valid_s1 || b_take;
	assign in_xfer  = in_valid && in_ready;

	// block position counters
	logic [CW-1:0] blk_col_q;
	logic [RW-1:0] blk_row_q;
	logic          col_end, row_end;

	assign col_end = (14'(blk_col_q) + 14'd1) >= across_eff;
	assign row_end = (14'(blk_row_q) + 14'd1) >= down_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_col_q <= '0;
			blk_row_q <= '0;
		end else if (in_xfer) begin
			if (col_end) begin
				blk_col_q <= '0;
				blk_row_q <= row_end ? '0 : blk_row_q + RW'(1);
			end else begin
				blk_col_q <= blk_col_q + CW'(1);
			end
		end
	end

	// stage 1: raw words, widened end colors, block position
	rgb_t          e0_s1, e1_s1;
	logic [63:0]   alpha_s1;
	logic [31:0]   idx_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          last_img_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			a_valid_s1 <= 1'b1;
		end else if (b_take) begin
			a_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			e0_s1       <= expand565(color_word[15:0]);
			e1_s1       <= expand565(color_word[31:16]);
			alpha_s1    <= alpha_word;
			idx_s1      <= color_word[63:32];
			col_s1      <= blk_col_q;
			row_s1      <= blk_row_q;
			last_img_s1 <= col_end && row_end;
		end
	end

	// stage 2: four-entry palette, pixel sequencing
	rgb_t          c2_mix, c3_mix;
	rgb_t          pal_s2 [4];
	logic [63:0]   alpha_s2;
	logic [31:0]   idx_s2;
	logic [CW-1:0] col_s2;
	logic [RW-1:0] row_s2;
	logic          last_img_s2;

	dxt3_palette u_palette (
		.e0 (e0_s1),
		.e1 (e1_s1),
		.c2 (c2_mix),
		.c3 (c3_mix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_s2 <= 1'b0;
			pix_cnt_s2 <= '0;
		end else begin
			if (b_take) begin
				b_valid_s2 <= 1'b1;
			end else if (b_done) begin
				b_valid_s2 <= 1'b0;
			end
			if (out_load) begin
				pix_cnt_s2 <= pix_cnt_s2 + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b_take) begin
			pal_s2[0]   <= e0_s1;
			pal_s2[1]   <= e1_s1;
			pal_s2[2]   <= c2_mix;
			pal_s2[3]   <= c3_mix;
			alpha_s2    <= alpha_s1;
			idx_s2      <= idx_s1;
			col_s2      <= col_s1;
			row_s2      <= row_s1;
			last_img_s2 <= last_img_s1;
		end
	end

	// pixel select
	logic [1:0]  sel;
	logic [3:0]  nib;
	rgb_t        pix;
	logic [13:0] px_full, py_full;

	assign sel     = idx_s2[{pix_cnt_s2, 1'b0} +: 2];
	assign nib     = alpha_s2[{pix_cnt_s2, 2'b00} +: 4];
	assign pix     = pal_s2[sel];
	assign px_full = 14'({col_s2, pix_cnt_s2[1:0]});
	assign py_full = 14'({row_s2, pix_cnt_s2[3:2]});

	// stage 3: output register
	logic [7:0]  blue_s3, green_s3, red_s3, alpha_s3;
	logic [11:0] px_s3, py_s3;
	logic        lob_s3, loi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s3 <= 1'b0;
		end else if (out_load) begin
			out_valid_s3 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			blue_s3  <= pix.blue;
			green_s3 <= pix.green;
			red_s3   <= pix.red;
			alpha_s3 <= {nib, nib};
			px_s3    <= px_full[11:0];
			py_s3    <= py_full[11:0];
			lob_s3   <= pix_cnt_s2 == 4'd15;
			loi_s3   <= (pix_cnt_s2 == 4'd15) && last_img_s2;
		end
	end

	assign out_valid     = out_valid_s3;
	assign out_blue      = blue_s3;
	assign out_green     = green_s3;
	assign out_red       = red_s3;
	assign out_alpha     = alpha_s3;
	assign pixel_x       = px_s3;
	assign pixel_y       = py_s3;
	assign last_of_block = lob_s3;
	assign last_of_image = loi_s3;

`ifndef SYNTH
	a_image_end_is_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_image |-> last_of_block)
		else $error("last_of_image without last_of_block");

	a_empty_stage_counter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!b_valid_s2 |-> pix_cnt_s2 == 4'd0)
		else $error("pixel counter moved with no block in palette stage");

	a_empty_intake_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!a_valid_s1 |-> in_ready)
		else $error("intake empty but not ready");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		14'(blk_col_q) < MAX_ACROSS_C)
		else $error("block column beyond maximum");
`endif

endmodule
